@@ sv/lsd_pkg.sv @@
// Shared constants and types for the LSD radix sorter.
// Used by the channel interfaces and the sorter top level.
package lsd_pkg;
  localparam int MaxKeys   = 64;
  localparam int DigitBits = 8;
  localparam int KeyBits   = 32;
  localparam int Radix     = 1 << DigitBits;
  localparam int Passes    = (KeyBits + DigitBits - 1) / DigitBits;
  localparam int IdxW      = $clog2(MaxKeys);
  localparam int CntW      = $clog2(MaxKeys + 1);
  localparam int DigW      = DigitBits;
  localparam int PassW     = (Passes > 1) ? $clog2(Passes) : 1;

  typedef logic [KeyBits-1:0] key_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [DigW-1:0]    dig_t;
endpackage

@@ sv/lsd_if.sv @@
// Valid/ready channel interfaces for input keys and sorted results.
// Depends on lsd_pkg.
interface lsd_in_if import lsd_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  key_t key;
  logic last_key;
  modport source (output valid, key, last_key, input ready);
  modport sink   (input valid, key, last_key, output ready);
endinterface

interface lsd_out_if import lsd_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  key_t sorted_key;
  logic last_out;
  logic overflow;
  modport source (output valid, sorted_key, last_out, overflow, input ready);
  modport sink   (input valid, sorted_key, last_out, overflow, output ready);
endinterface

@@ sv/lsd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Standalone; no package dependency.
module lsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/lsd_radix_sorter.sv @@
// LSD radix sorter: key buffers, count store and the pass sequencer.
// Depends on lsd_pkg, lsd_if and lsd_ram.
//
// Usage:
//  Keys arrive on the in channel, one transaction per key, one per cycle
//  while loading. A transaction with last_key high closes the set. Up to
//  MaxKeys keys are kept; later keys of a set are dropped and the overflow
//  bit is set on every result of that set.
//  After the last key the block is not ready while it runs four passes over
//  8-bit digits. Each pass clears the 256-entry count store, counts digits,
//  forms prefix sums and scatters. Results then leave from an output
//  register, ascending unsigned, last_out on the final key. When the
//  receiver stalls, the result holds, emission waits and the input stays
//  not ready. Loading of the next set may start while the final result
//  still waits in the output register. Reset returns the block to loading
//  an empty set.
module lsd_radix_sorter import lsd_pkg::*; (
  input logic clk,
  input logic rst,
  lsd_in_if.sink    in_ch,
  lsd_out_if.source out_ch
);
  localparam logic [3:0] S_LOAD = 4'd0, S_CLR = 4'd1, S_CRD = 4'd2, S_CINC = 4'd3,
    S_PRD = 4'd4, S_PWR = 4'd5, S_SRD = 4'd6, S_SWR = 4'd7, S_ERD = 4'd8,
    S_EOUT = 4'd9, S_CWT = 4'd10, S_SWT = 4'd11;

  logic [3:0] state;
  cnt_t fill_count;
  logic overflow_seen;
  idx_t i;
  dig_t bin;
  logic [PassW-1:0] pass;
  logic src_b;
  cnt_t run;
  dig_t dig_r;

  // Key stores and the count store.
  logic a_we, b_we, c_we;
  idx_t a_wa, b_wa, k_ra;
  key_t a_wd, b_wd, a_rd, b_rd, src_rd;
  dig_t c_wa, c_ra;
  cnt_t c_wd, c_rd;

  lsd_ram #(.Width(KeyBits), .Depth(MaxKeys)) u_ka (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(k_ra), .rdata(a_rd));
  lsd_ram #(.Width(KeyBits), .Depth(MaxKeys)) u_kb (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(k_ra), .rdata(b_rd));
  lsd_ram #(.Width(CntW), .Depth(Radix)) u_cnt (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));

  assign src_rd = src_b ? b_rd : a_rd;

  // Digit of the key being read in this pass.
  dig_t cur_dig;
  assign cur_dig = dig_t'(src_rd >> (int'(pass) * DigitBits));

  logic last_i;
  assign last_i = (cnt_t'(i) + cnt_t'(1)) == fill_count;

  // Loading accepts a key whenever the block is in the load state.
  logic in_fire;
  assign in_ch.ready = state == S_LOAD;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Memory port steering.
  always_comb begin
    a_we = 1'b0; b_we = 1'b0; c_we = 1'b0;
    a_wa = '0;   b_wa = '0;   a_wd = '0; b_wd = '0;
    c_wa = bin;  c_wd = '0;   c_ra = bin;
    k_ra = i;
    unique case (state)
      S_LOAD: begin
        a_we = in_fire && fill_count < cnt_t'(MaxKeys);
        a_wa = idx_t'(fill_count);
        a_wd = in_ch.key;
      end
      S_CLR: c_we = 1'b1;
      S_CINC, S_SWT: c_ra = cur_dig;
      S_CWT: begin
        c_we = 1'b1; c_wa = dig_r; c_wd = c_rd + cnt_t'(1);
      end
      S_PWR: begin
        c_we = 1'b1; c_wd = run;
      end
      S_SWR: begin
        c_we = 1'b1; c_wa = dig_r; c_wd = c_rd + cnt_t'(1);
        a_we = src_b;  a_wa = idx_t'(c_rd); a_wd = src_rd;
        b_we = !src_b; b_wa = idx_t'(c_rd); b_wd = src_rd;
      end
      default: begin end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; fill_count <= '0; overflow_seen <= 1'b0;
      i <= '0; bin <= '0; pass <= '0; src_b <= 1'b0; run <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: if (in_fire) begin
          if (fill_count < cnt_t'(MaxKeys)) fill_count <= fill_count + cnt_t'(1);
          else overflow_seen <= 1'b1;
          if (in_ch.last_key) begin
            state <= S_CLR; bin <= '0; pass <= '0; src_b <= 1'b0;
          end
        end
        S_CLR: begin
          bin <= bin + dig_t'(1);
          if (bin == dig_t'(Radix - 1)) begin
            state <= S_CRD; i <= '0;
          end
        end
        S_CRD: state <= S_CINC;
        S_CINC: begin
          dig_r <= cur_dig; state <= S_CWT;
        end
        S_CWT: begin
          if (last_i) begin
            state <= S_PRD; bin <= '0; run <= '0;
          end else begin
            i <= i + idx_t'(1); state <= S_CRD;
          end
        end
        S_PRD: state <= S_PWR;
        S_PWR: begin
          run <= run + c_rd;
          bin <= bin + dig_t'(1);
          if (bin == dig_t'(Radix - 1)) begin
            state <= S_SRD; i <= '0;
          end else state <= S_PRD;
        end
        S_SRD: state <= S_SWT;
        S_SWT: begin
          dig_r <= cur_dig; state <= S_SWR;
        end
        S_SWR: begin
          if (last_i) begin
            src_b <= !src_b; i <= '0; bin <= '0;
            if (pass == PassW'(Passes - 1)) state <= S_ERD;
            else begin
              pass <= pass + PassW'(1); state <= S_CLR;
            end
          end else begin
            i <= i + idx_t'(1); state <= S_SRD;
          end
        end
        S_ERD: state <= S_EOUT;
        S_EOUT: if (!out_ch.valid || out_ch.ready) begin
          out_ch.valid <= 1'b1;
          out_ch.sorted_key <= src_rd;
          out_ch.last_out <= last_i;
          out_ch.overflow <= overflow_seen;
          if (last_i) begin
            state <= S_LOAD; fill_count <= '0; overflow_seen <= 1'b0;
          end else begin
            i <= i + idx_t'(1); state <= S_ERD;
          end
        end
        default: state <= S_LOAD;
      endcase
      if (out_ch.valid && out_ch.ready && !(state == S_EOUT)) out_ch.valid <= 1'b0;
    end
  end
endmodule
